/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CBTS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbts assertion failed");

// Next-cycle implication, disabled in reset.
`define CBTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbts assertion failed");

`endif

/* rtl/core/cbts_pkg.sv */
// Package: widths, constants and state type of the CAN bit timing search unit.
package cbts_pkg;

   localparam int CLOCK_W = 27;
   localparam int RATE_W  = 24;
   localparam int SPM_W   = 10;
   localparam int TW_W    = 32;
   localparam int TQ_W    = 10;
   localparam int SP_W    = 11;
   localparam int PROD_W  = SPM_W + TQ_W;
   localparam int SREM_W  = 10;
   localparam int CNT_W   = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int PRESCALE_LIMIT_DEF = 256;

   localparam logic [CLOCK_W-1:0]    CLK_RESET     = CLOCK_W'(40000000);
   localparam logic [TQ_W-1:0]       TQ_MIN        = TQ_W'(8);
   localparam logic [TQ_W-1:0]       TQ_MAX        = TQ_W'(385);
   localparam logic [SP_W-1:0]       PERMILLE      = SP_W'(1000);
   localparam logic [SP_W-1:0]       SP_MIN        = SP_W'(2);
   localparam logic [SP_W-1:0]       SP_MAX        = SP_W'(257);
   localparam logic [SP_W-1:0]       TSEG2_MAX     = SP_W'(128);
   localparam logic [CSR_ADDR_W-1:0] ADDR_CLOCK_HZ = CSR_ADDR_W'(0);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_TOTAL,
      ST_TRIAL,
      ST_DIV_TQ,
      ST_CHK_TQ,
      ST_MUL,
      ST_DIV_SP,
      ST_EVAL,
      ST_FINISH
   } state_type;

endpackage

/* rtl/core/cbts_chan_if.sv */
// Request and response channel interfaces of the bit timing search unit.
interface cbts_req_if;
   import cbts_pkg::*;
   logic              valid;
   logic              ready;
   logic [RATE_W-1:0] bit_rate;
   logic [SPM_W-1:0]  sample_point_permille;
   modport source (output valid, output bit_rate, output sample_point_permille, input ready);
   modport sink   (input valid, input bit_rate, input sample_point_permille, output ready);
endinterface

interface cbts_rsp_if;
   import cbts_pkg::*;
   logic            valid;
   logic            ready;
   logic            found;
   logic [TW_W-1:0] timing_word;
   modport source (output valid, output found, output timing_word, input ready);
   modport sink   (input valid, input found, input timing_word, output ready);
endinterface

/* rtl/core/can_bit_timing_search_unit.sv */
// Top level: bit-serial CAN nominal bit timing search with APB-style clock register.
// One request first forms the bit-serial quotient clock_hz / bit_rate, then tries each
// prescaler in turn: one whose quanta count is 1024 or more is skipped at once, one whose
// quanta count is 386 to 1023 gets the quanta division and range check, and one that is
// fully evaluated gets the quanta division, a shift-add multiply by the sample point, a
// division by 1000 and the checks; the search stops at the first fit, as soon as the quanta
// count drops below 8, or once the prescaler passes PRESCALE_LIMIT. A zero bit rate skips
// the search and answers with no fit. The finished word sits in an output register, so a
// new request is taken while it waits.
module can_bit_timing_search_unit #(
   parameter int PRESCALE_LIMIT = cbts_pkg::PRESCALE_LIMIT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   cbts_req_if.sink                            req_ch,
   cbts_rsp_if.source                          rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cbts_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cbts_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cbts_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import cbts_pkg::*;

   localparam int BRP_W = $clog2(PRESCALE_LIMIT + 2);
   localparam int HI_W  = CLOCK_W - TQ_W;

   state_type state_ff, state_in;

   logic [CLOCK_W-1:0] clock_hz_ff;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [SPM_W-1:0]   spm_ff, spm_in;
   logic [CLOCK_W-1:0] total_ff, total_in;
   logic [RATE_W-1:0]  rem_ff, rem_in;
   logic [TQ_W-1:0]    tq_ff, tq_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [SPM_W-1:0]   mul_sh_ff, mul_sh_in;
   logic [SP_W-1:0]    sp_ff, sp_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [BRP_W-1:0]   brp_ff, brp_in;
   logic               found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [TW_W-1:0]    rsp_word_ff, rsp_word_in;

   logic               req_take;
   logic               out_free;
   logic               csr_wr;
   logic [RATE_W:0]    rem_t;
   logic               ge_t;
   logic [BRP_W:0]     rem_q;
   logic               ge_q;
   logic [SREM_W:0]    rem_s;
   logic               ge_s;
   logic [PROD_W-1:0]  prod_nx;
   logic [SP_W-1:0]    tq_ext;
   logic [SP_W-1:0]    tseg2;
   logic               eval_ok;
   logic [BRP_W-1:0]   brp_m1;
   logic [7:0]         tseg2_m1;
   logic [TW_W-1:0]    word;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.timing_word = rsp_word_ff;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == ADDR_CLOCK_HZ) ? CSR_DATA_W'(clock_hz_ff) : '0;

   // one restoring step per datapath
   assign rem_t = {rem_ff, total_ff[CLOCK_W-1]};
   assign ge_t  = (rem_t >= {1'b0, rate_ff});
   assign rem_q = {rem_ff[BRP_W-1:0], tq_ff[TQ_W-1]};
   assign ge_q  = (rem_q >= {1'b0, brp_ff});
   assign rem_s = {rem_ff[SREM_W-1:0], sp_ff[SP_W-1]};
   assign ge_s  = (rem_s >= PERMILLE);

   assign prod_nx = {prod_ff[PROD_W-2:0], 1'b0}
                    + (mul_sh_ff[SPM_W-1] ? PROD_W'(tq_ff) : '0);

   assign tq_ext   = SP_W'(tq_ff);
   assign tseg2    = tq_ext - sp_ff;
   assign eval_ok  = (sp_ff >= SP_MIN) && (sp_ff <= SP_MAX) && (tq_ext > sp_ff)
                     && (tseg2 <= TSEG2_MAX);
   assign brp_m1   = brp_ff - BRP_W'(1);
   assign tseg2_m1 = 8'(tseg2 - SP_W'(1));
   assign word     = found_ff ? {tseg2_m1, tseg2_m1, 8'(sp_ff - SP_W'(2)), 8'(brp_m1)} : '0;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (req_ch.bit_rate == '0) ? ST_FINISH : ST_DIV_TOTAL;
            end
         end
         ST_DIV_TOTAL: begin
            if (cnt_ff == CNT_W'(CLOCK_W - 1)) begin
               state_in = ST_TRIAL;
            end
         end
         ST_TRIAL: begin
            if (brp_ff > BRP_W'(PRESCALE_LIMIT)) begin
               state_in = ST_FINISH;
            end else if (total_ff[CLOCK_W-1:TQ_W] < HI_W'(brp_ff)) begin
               state_in = ST_DIV_TQ;
            end
         end
         ST_DIV_TQ: begin
            if (cnt_ff == CNT_W'(TQ_W - 1)) begin
               state_in = ST_CHK_TQ;
            end
         end
         ST_CHK_TQ: begin
            if (tq_ff < TQ_MIN) begin
               state_in = ST_FINISH;
            end else if (tq_ff > TQ_MAX) begin
               state_in = ST_TRIAL;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (cnt_ff == CNT_W'(SPM_W - 1)) begin
               state_in = ST_DIV_SP;
            end
         end
         ST_DIV_SP: begin
            if (cnt_ff == CNT_W'(SP_W - 1)) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = eval_ok ? ST_FINISH : ST_TRIAL;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rate_in      = rate_ff;
      spm_in       = spm_ff;
      total_in     = total_ff;
      rem_in       = rem_ff;
      tq_in        = tq_ff;
      prod_in      = prod_ff;
      mul_sh_in    = mul_sh_ff;
      sp_in        = sp_ff;
      cnt_in       = cnt_ff;
      brp_in       = brp_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in = rsp_found_ff;
      rsp_word_in  = rsp_word_ff;
      case (state_ff)
         ST_IDLE: begin
            rate_in  = req_ch.bit_rate;
            spm_in   = req_ch.sample_point_permille;
            total_in = clock_hz_ff;
            rem_in   = '0;
            cnt_in   = '0;
            brp_in   = BRP_W'(1);
            found_in = 1'b0;
         end
         ST_DIV_TOTAL: begin
            rem_in   = ge_t ? RATE_W'(rem_t - {1'b0, rate_ff}) : RATE_W'(rem_t);
            total_in = {total_ff[CLOCK_W-2:0], ge_t};
            cnt_in   = cnt_ff + CNT_W'(1);
         end
         ST_TRIAL: begin
            if (total_ff[CLOCK_W-1:TQ_W] >= HI_W'(brp_ff)) begin
               brp_in = brp_ff + BRP_W'(1);
            end
            rem_in = RATE_W'(total_ff[CLOCK_W-1:TQ_W]);
            tq_in  = total_ff[TQ_W-1:0];
            cnt_in = '0;
         end
         ST_DIV_TQ: begin
            rem_in = ge_q ? RATE_W'(BRP_W'(rem_q - {1'b0, brp_ff})) : RATE_W'(BRP_W'(rem_q));
            tq_in  = {tq_ff[TQ_W-2:0], ge_q};
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_CHK_TQ: begin
            if (tq_ff > TQ_MAX) begin
               brp_in = brp_ff + BRP_W'(1);
            end
            prod_in   = '0;
            mul_sh_in = spm_ff;
            cnt_in    = '0;
         end
         ST_MUL: begin
            prod_in   = prod_nx;
            mul_sh_in = {mul_sh_ff[SPM_W-2:0], 1'b0};
            rem_in    = RATE_W'(prod_nx[PROD_W-1:SP_W]);
            sp_in     = prod_nx[SP_W-1:0];
            cnt_in    = (cnt_ff == CNT_W'(SPM_W - 1)) ? '0 : cnt_ff + CNT_W'(1);
         end
         ST_DIV_SP: begin
            rem_in = ge_s ? RATE_W'(SREM_W'(rem_s - PERMILLE)) : RATE_W'(SREM_W'(rem_s));
            sp_in  = {sp_ff[SP_W-2:0], ge_s};
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_EVAL: begin
            if (eval_ok) begin
               found_in = 1'b1;
            end else begin
               brp_in = brp_ff + BRP_W'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_word_in  = word;
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         clock_hz_ff  <= CLK_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr && (csr_paddr == ADDR_CLOCK_HZ)) begin
            clock_hz_ff <= csr_pwdata[CLOCK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rate_ff      <= rate_in;
      spm_ff       <= spm_in;
      total_ff     <= total_in;
      rem_ff       <= rem_in;
      tq_ff        <= tq_in;
      prod_ff      <= prod_in;
      mul_sh_ff    <= mul_sh_in;
      sp_ff        <= sp_in;
      cnt_ff       <= cnt_in;
      brp_ff       <= brp_in;
      found_ff     <= found_in;
      rsp_found_ff <= rsp_found_in;
      rsp_word_ff  <= rsp_word_in;
   end

endmodule

/* rtl/core/cbts_checker.sv */
// Port-level assertion checker for the bit timing search unit, with its bind.
`include "assert_macros.svh"

module cbts_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_found,
   input logic [cbts_pkg::TW_W-1:0] rsp_timing_word
);
   import cbts_pkg::*;

   `CBTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_timing_word) && $stable(rsp_found))
   `CBTS_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)
   `CBTS_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_found, rsp_timing_word == '0)
   `CBTS_ASSERT_NOW(a_sjw_eq_tseg2, clock, reset, rsp_valid && rsp_found, rsp_timing_word[31:24] == rsp_timing_word[23:16])
   `CBTS_ASSERT_NOW(a_tseg2_range, clock, reset, rsp_valid && rsp_found, rsp_timing_word[23] == 1'b0)

endmodule

bind can_bit_timing_search_unit cbts_checker u_cbts_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_found       (rsp_ch.found),
   .rsp_timing_word (rsp_ch.timing_word)
);

/* tb/sv/can_bit_timing_search_unit_test.sv */
// Self-checking testbench for the CAN bit timing search unit: directed table, then random requests.
module can_bit_timing_search_unit_test;
   import cbts_pkg::*;

   localparam int SEARCH_LIMIT      = PRESCALE_LIMIT_DEF;
   localparam int NUM_DIRECTED      = 19;
   localparam int NUM_PHASES        = 8;
   localparam int PHASE_LONG_HOLD   = 3;
   localparam int PHASE_STRAY_WRITE = 5;
   localparam int LONG_HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES      = 9000;   // longer than the slowest search
   localparam int QUIET_LIMIT       = 60000;
   localparam bit TYPED             = 1'b1;
   localparam bit CALC              = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNUSED = CSR_ADDR_W'(4);

   typedef struct packed {
      logic            found;
      logic [TW_W-1:0] timing_word;
   } timing_result_type;

   typedef struct packed {
      logic [RATE_W-1:0] rate;
      logic [SPM_W-1:0]  spm;
      logic              typed;
      timing_result_type want;
   } dir_row_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   cbts_req_if req_ch();
   cbts_rsp_if rsp_ch();

   can_bit_timing_search_unit #(.PRESCALE_LIMIT(SEARCH_LIMIT)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   timing_result_type pending_timing_q[$];
   timing_result_type pend_result;
   timing_result_type got_result;
   timing_result_type want_result;
   logic [CLOCK_W-1:0] clk_setting;
   bit idle_on;
   int hold_request;
   int stall_left;
   int errors;
   int requests_taken;
   int results_found;
   int results_missed;
   int clock_settings;
   int quiet_cycles;

   int unsigned std_rates [9] = '{10000, 20000, 50000, 100000, 125000, 250000,
                                  500000, 800000, 1000000};

   logic [31:0] phase_clock [NUM_PHASES] = '{
      32'd40000000, 32'd1, 32'hF000_0000, 32'd100000000,
      32'hFFFF_FFFF, 32'd80000000, 32'd20000000, 32'd40000000};

   int phase_items [NUM_PHASES] = '{10, 8, 8, 11, 10, 11, 12, 11};

   dir_row_type dir_rows [NUM_DIRECTED] = '{
      '{24'd0,        10'd875,  TYPED, '{1'b0, 32'h0}},
      '{24'd0,        10'd1023, TYPED, '{1'b0, 32'h0}},
      '{24'hFFFFFF,   10'd0,    TYPED, '{1'b0, 32'h0}},
      '{24'd500000,   10'd875,  TYPED, '{1'b1, 32'h0909_4400}},
      '{24'd1000000,  10'd800,  TYPED, '{1'b1, 32'h0707_1E00}},
      '{24'd1,        10'd1023, TYPED, '{1'b0, 32'h0}},
      '{24'd125000,   10'd875,  TYPED, '{1'b1, 32'h1313_8A01}},
      '{24'd5000000,  10'd875,  TYPED, '{1'b1, 32'h0000_0500}},
      '{24'd5000000,  10'd250,  TYPED, '{1'b1, 32'h0505_0000}},
      '{24'd103896,   10'd668,  TYPED, '{1'b1, 32'h7F7F_FF00}},
      '{24'd6000000,  10'd875,  TYPED, '{1'b0, 32'h0}},
      '{24'd500000,   10'd1000, CALC,  '{1'b0, 32'h0}},
      '{24'd20000,    10'd0,    CALC,  '{1'b0, 32'h0}},
      '{24'd100000,   10'd100,  CALC,  '{1'b0, 32'h0}},
      '{24'd250000,   10'd1023, CALC,  '{1'b0, 32'h0}},
      '{24'd10000,    10'd875,  CALC,  '{1'b0, 32'h0}},
      '{24'h800000,   10'h200,  CALC,  '{1'b0, 32'h0}},
      '{24'h7FFFFF,   10'h1FF,  CALC,  '{1'b0, 32'h0}},
      '{24'd4000,     10'd875,  CALC,  '{1'b0, 32'h0}}
   };

   function automatic timing_result_type predict_timing(input logic [CLOCK_W-1:0] clk_hz,
                                                        input logic [RATE_W-1:0] rate,
                                                        input logic [SPM_W-1:0] spm);
      timing_result_type res;
      int unsigned total;
      int unsigned brp;
      int unsigned tq;
      int unsigned sp;
      int unsigned tseg1;
      int unsigned tseg2;
      res = '0;
      if (rate == 0) return res;
      total = clk_hz / rate;
      for (brp = 1; brp <= SEARCH_LIMIT && !res.found; brp++) begin
         tq = total / brp;
         sp = (spm * tq) / PERMILLE;
         if (tq >= TQ_MIN && tq <= TQ_MAX && sp >= SP_MIN && sp <= SP_MAX && tq >= sp + 1) begin
            tseg1 = sp - 1;
            tseg2 = tq - 1 - tseg1;
            if (tseg2 <= TSEG2_MAX) begin
               res.found = 1'b1;
               res.timing_word = {8'(tseg2 - 1), 8'(tseg2 - 1), 8'(tseg1 - 1), 8'(brp - 1)};
            end
         end
      end
      return res;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // scoreboard: results checked in order, accepted requests queued
   always @(posedge clock) begin
      if (!reset) begin
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_result.found = rsp_ch.found;
            got_result.timing_word = rsp_ch.timing_word;
            if (pending_timing_q.size() == 0) begin
               $error("result word with nothing outstanding");
               errors++;
            end else begin
               want_result = pending_timing_q.pop_front();
               if (got_result.found !== want_result.found) begin
                  $error("found: expected %0d, got %0d", want_result.found, got_result.found);
                  errors++;
               end
               if (got_result.timing_word !== want_result.timing_word) begin
                  $error("timing_word: expected %h, got %h",
                         want_result.timing_word, got_result.timing_word);
                  errors++;
               end
            end
            if (got_result.found === 1'b1) results_found++;
            else results_missed++;
         end
         if (req_ch.valid && req_ch.ready) begin
            pending_timing_q.push_back(pend_result);
            requests_taken++;
         end
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      stall_left = 0;
      @(negedge clock);
      forever begin
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end
         rsp_ch.ready = (stall_left == 0);
         if (stall_left > 0) stall_left--;
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) stall_left = idle_on ? $urandom_range(0, 6) : 0;
         @(negedge clock);
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = addr;
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      if (addr == ADDR_CLOCK_HZ) clk_setting = data[CLOCK_W-1:0];
   endtask

   task automatic csr_check_clock();
      logic [CSR_DATA_W-1:0] got;
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = ADDR_CLOCK_HZ;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      if (got !== CSR_DATA_W'(clk_setting)) begin
         $error("clock_hz: expected %0d, got %0d", clk_setting, got);
         errors++;
      end
   endtask

   // entered and left at a falling edge; valid stays high on return
   task automatic send_request(input logic [RATE_W-1:0] rate, input logic [SPM_W-1:0] spm,
                               input bit typed, input timing_result_type want);
      int gap;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      pend_result = typed ? want : predict_timing(clk_setting, rate, spm);
      req_ch.bit_rate = rate;
      req_ch.sample_point_permille = spm;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic pick_random(output logic [RATE_W-1:0] rate, output logic [SPM_W-1:0] spm);
      if ($urandom_range(0, 9) < 7) begin
         if ($urandom_range(0, 4) < 3) rate = RATE_W'(std_rates[$urandom_range(0, 8)]);
         else rate = RATE_W'($urandom_range(5000, 1000000));
         spm = SPM_W'($urandom_range(500, 950));
      end else begin
         rate = ($urandom_range(0, 7) == 0) ? '0 : RATE_W'($urandom);
         spm = SPM_W'($urandom);
      end
   endtask

   task automatic drain_requests();
      req_ch.valid = 1'b0;
      while (pending_timing_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      logic [RATE_W-1:0] rate;
      logic [SPM_W-1:0] spm;
      int ph;
      int i;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.bit_rate = '0;
      req_ch.sample_point_permille = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      clk_setting = CLK_RESET;
      idle_on = 1'b1;
      hold_request = 0;
      errors = 0;
      requests_taken = 0;
      results_found = 0;
      results_missed = 0;
      clock_settings = 1;
      quiet_cycles = 0;
      pend_result = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      csr_check_clock();

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         drain_requests();
         idle_on = (ph % 3) != 2;
         if (ph == PHASE_STRAY_WRITE) begin
            csr_write(ADDR_UNUSED, 32'hDEAD_BEEF);
            csr_check_clock();
         end
         if (ph > 0) begin
            csr_write(ADDR_CLOCK_HZ, phase_clock[ph]);
            csr_check_clock();
            clock_settings++;
         end
         if (ph == 0) begin
            for (i = 0; i < NUM_DIRECTED; i++)
               send_request(dir_rows[i].rate, dir_rows[i].spm, dir_rows[i].typed,
                            dir_rows[i].want);
         end
         if (ph == PHASE_LONG_HOLD) hold_request = LONG_HOLD_CYCLES;
         for (i = 0; i < phase_items[ph]; i++) begin
            if (i == phase_items[ph] / 2) drain_requests();
            pick_random(rate, spm);
            send_request(rate, spm, CALC, '0);
         end
      end

      drain_requests();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("%0d requests over %0d clock settings, incl. zero rate, zero clock, no fit.",
               requests_taken, clock_settings);
      $display("%0d searches found a timing, %0d did not.", results_found, results_missed);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/cbts_pkg.sv
rtl/core/cbts_chan_if.sv
rtl/core/can_bit_timing_search_unit.sv
rtl/core/cbts_checker.sv
tb/sv/can_bit_timing_search_unit_test.sv
